### sv/b2da_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b2da_pkg: binary to decimal ascii shared definitions
// Widths, digit count and control types shared by the converter and its cells.
// ----------------------------------------------------------------------------
package b2da_pkg;

    localparam int VALUE_BITS  = 32;
    // decimal digits of 2^VALUE_BITS - 1, using 1233/4096 as log10(2)
    localparam int DIGITS      = ((VALUE_BITS * 1233) >> 12) + 1;
    localparam int BIT_CNT_W   = $clog2(VALUE_BITS + 1);
    localparam int DIGIT_CNT_W = $clog2(DIGITS + 1);

    localparam int             BCD_W      = 4;
    localparam int             CHAR_W     = 6;
    localparam logic [1:0]     ASCII_HIGH = 2'b11;
    localparam logic [BCD_W-1:0] BCD_FIVE  = 4'd5;
    localparam logic [BCD_W-1:0] BCD_THREE = 4'd3;

    typedef logic [BCD_W-1:0] bcd_t;

    typedef struct packed {
        logic clear;
        logic convert;
        logic shift_up;
    } cell_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'b001,
        ST_CONVERT = 3'b010,
        ST_EMIT    = 3'b100
    } state_t;

endpackage
`default_nettype wire

### sv/b2da_digit_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// b2da_digit_cell: one decimal digit of the conversion chain
// Shift-and-adjust step while converting, digit hand-over while emitting.
// ----------------------------------------------------------------------------
module b2da_digit_cell (
    input  wire                 clk,
    input  b2da_pkg::cell_ctrl_t ctrl,
    input  wire                 bit_in,
    input  b2da_pkg::bcd_t      digit_in,
    output logic                bit_out,
    output b2da_pkg::bcd_t      digit
);
    import b2da_pkg::*;

    bcd_t digit_reg;
    bcd_t digit_next;
    bcd_t adjusted;

    assign adjusted = (digit_reg >= BCD_FIVE) ? bcd_t'(digit_reg + BCD_THREE) : digit_reg;
    assign bit_out  = adjusted[BCD_W-1];
    assign digit    = digit_reg;

    always_comb
    begin
        digit_next = digit_reg;
        if (ctrl.clear)
        begin
            digit_next = '0;
        end
        else if (ctrl.convert)
        begin
            digit_next = {adjusted[BCD_W-2:0], bit_in};
        end
        else if (ctrl.shift_up)
        begin
            digit_next = digit_in;
        end
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

endmodule
`default_nettype wire

### sv/binary_to_decimal_ascii.sv
`default_nettype none
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii: unsigned binary to decimal ascii text
// Converts one value through a chain of bcd digit cells, then emits its digits
// most significant first with leading zeros suppressed.
// ----------------------------------------------------------------------------
//  channel | handshake          | payload
//  in      | in_valid, in_stall | value
//  out     | out_valid, out_stall | digit_char, last_digit
//
//  per value: a load, then a shift-and-adjust step for each value bit, then a step
//  per dropped leading zero and one per emitted digit (1 to 10 digits)
//  the bit counter sets the conversion length; one bit enters the cell chain per cycle
//  reset clears the sequencer and the output valid; digit cells need no reset
//  a stalled output holds its transfer; the next value is taken once idle
module binary_to_decimal_ascii (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 in_valid,
    output logic                                in_stall,
    input  wire [b2da_pkg::VALUE_BITS-1:0]      value,
    output logic                                out_valid,
    input  wire                                 out_stall,
    output logic [b2da_pkg::CHAR_W-1:0]         digit_char,
    output logic                                last_digit
);
    import b2da_pkg::*;

    state_t                 state_reg, state_next;
    logic [VALUE_BITS-1:0]  bits_reg, bits_next;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [DIGIT_CNT_W-1:0] digit_cnt_reg, digit_cnt_next;
    logic                   started_reg, started_next;
    logic                   out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0]      char_reg, char_next;
    logic                   last_reg, last_next;

    cell_ctrl_t             ctrl;
    logic                   carry [DIGITS];
    bcd_t                   digits [DIGITS];
    bcd_t                   top_digit;
    logic                   in_take;
    logic                   skip;
    logic                   load_out;

    assign top_digit = digits[DIGITS-1];
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_take   = in_valid && (state_reg == ST_IDLE);
    assign skip      = (state_reg == ST_EMIT) && !started_reg && (top_digit == '0)
                       && (digit_cnt_reg > DIGIT_CNT_W'(1));
    assign load_out  = (state_reg == ST_EMIT) && !skip && (!out_valid_reg || !out_stall);

    assign carry[0] = bits_reg[VALUE_BITS-1];

    genvar i;
    generate
        for (i = 0; i < DIGITS; i++)
        begin : g_cell
            if (i > 0)
            begin : g_link
                if (i < DIGITS-1)
                begin : g_mid
                    b2da_digit_cell u_cell (
                        .clk      (clk),
                        .ctrl     (ctrl),
                        .bit_in   (carry[i]),
                        .digit_in (digits[i-1]),
                        .bit_out  (carry[i+1]),
                        .digit    (digits[i])
                    );
                end
                else
                begin : g_last
                    b2da_digit_cell u_cell (
                        .clk      (clk),
                        .ctrl     (ctrl),
                        .bit_in   (carry[i]),
                        .digit_in (digits[i-1]),
                        .bit_out  (),
                        .digit    (digits[i])
                    );
                end
            end
            else
            begin : g_first
                if (DIGITS > 1)
                begin : g_more
                    b2da_digit_cell u_cell (
                        .clk      (clk),
                        .ctrl     (ctrl),
                        .bit_in   (carry[0]),
                        .digit_in (bcd_t'(0)),
                        .bit_out  (carry[1]),
                        .digit    (digits[0])
                    );
                end
                else
                begin : g_only
                    b2da_digit_cell u_cell (
                        .clk      (clk),
                        .ctrl     (ctrl),
                        .bit_in   (carry[0]),
                        .digit_in (bcd_t'(0)),
                        .bit_out  (),
                        .digit    (digits[0])
                    );
                end
            end
        end
    endgenerate

    always_comb
    begin
        state_next     = state_reg;
        bits_next      = bits_reg;
        bit_cnt_next   = bit_cnt_reg;
        digit_cnt_next = digit_cnt_reg;
        started_next   = started_reg;
        char_next      = char_reg;
        last_next      = last_reg;
        ctrl           = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    ctrl.clear     = 1'b1;
                    bits_next      = value;
                    bit_cnt_next   = BIT_CNT_W'(VALUE_BITS);
                    digit_cnt_next = DIGIT_CNT_W'(DIGITS);
                    started_next   = 1'b0;
                    state_next     = ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                ctrl.convert = 1'b1;
                bits_next    = {bits_reg[VALUE_BITS-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg - BIT_CNT_W'(1);
                if (bit_cnt_reg == BIT_CNT_W'(1))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (skip || load_out)
                begin
                    ctrl.shift_up  = 1'b1;
                    digit_cnt_next = digit_cnt_reg - DIGIT_CNT_W'(1);
                end
                if (load_out)
                begin
                    started_next = 1'b1;
                    char_next    = {ASCII_HIGH, top_digit};
                    last_next    = (digit_cnt_reg == DIGIT_CNT_W'(1));
                    if (digit_cnt_reg == DIGIT_CNT_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid_next = load_out || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bit_cnt_reg   <= '0;
            digit_cnt_reg <= '0;
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bit_cnt_reg   <= bit_cnt_next;
            digit_cnt_reg <= digit_cnt_next;
            started_reg   <= started_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bits_reg <= bits_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

    assign out_valid  = out_valid_reg;
    assign digit_char = char_reg;
    assign last_digit = last_reg;

endmodule
`default_nettype wire
